// ----- design/vwbp_pkg.sv -----
// Shared types and constants for the variable-width bit packer.
// Holds the request, response and internal task structs and the back-end state type.
// Has no dependencies.
package vwbp_pkg;

   localparam int WORD_BITS  = 8;
   localparam int VALUE_BITS = 32;
   localparam int CNT_BITS   = 6;
   localparam int LEN_BITS   = $clog2(VALUE_BITS + 1);
   localparam int FREE_BITS  = $clog2(WORD_BITS + 1);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [CNT_BITS-1:0]   bit_count;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 last_word;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] bits;
      logic [LEN_BITS-1:0]   len;
      logic                  last;
   } task_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      BK_IDLE,
      BK_PACK
   } back_state_type;

endpackage

// ----- design/vwbp_front.sv -----
// Front end of the bit packer: accepts requests, clamps the bit count and
// left-aligns the significant bits for the back end. Depends on vwbp_pkg.
module vwbp_front (
   input  logic                      req_push,
   output logic                      req_full,
   input  vwbp_pkg::req_type         req_item,
   input  vwbp_pkg::queue_status_type q_status,
   output logic                      q_push,
   output vwbp_pkg::task_type        q_data
);
   import vwbp_pkg::*;

   logic [LEN_BITS-1:0] len;

   always_comb begin
      if (req_item.bit_count > CNT_BITS'(VALUE_BITS)) begin
         len = LEN_BITS'(VALUE_BITS);
      end else begin
         len = LEN_BITS'(req_item.bit_count);
      end
   end

   assign req_full    = q_status.full;
   assign q_push      = req_push && !q_status.full;
   assign q_data.bits = req_item.value << (LEN_BITS'(VALUE_BITS) - len);
   assign q_data.len  = len;
   assign q_data.last = req_item.last;

endmodule

// ----- design/vwbp_queue.sv -----
// Short register queue of packing tasks between the front and back ends.
// Depends on vwbp_pkg.
module vwbp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_push,
   input  vwbp_pkg::task_type         q_wdata,
   input  logic                       q_pop,
   output vwbp_pkg::task_type         q_rdata,
   output vwbp_pkg::queue_status_type q_status
);
   import vwbp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   task_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_wdata;
      end
   end

   assign q_rdata        = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (!q_status.full || q_pop))
      else $error("push into full queue");

endmodule

// ----- design/vwbp_back.sv -----
// Back end of the bit packer: moves aligned bits into the current word one chunk per cycle
// (stalled when a finished word finds the output register full) and holds finished words there. Depends on vwbp_pkg.
module vwbp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vwbp_pkg::task_type         q_data,
   input  vwbp_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output vwbp_pkg::rsp_type          rsp_item
);
   import vwbp_pkg::*;

   back_state_type         state_ff, state_in;
   logic [WORD_BITS-1:0]   partial_ff, partial_in;
   logic [FREE_BITS-1:0]   free_ff, free_in;
   logic [VALUE_BITS-1:0]  bits_ff, bits_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic                   last_ff, last_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_data_ff, out_data_in;

   logic                   out_ok;
   logic [LEN_BITS-1:0]    take;
   logic [LEN_BITS-1:0]    len_next;
   logic [FREE_BITS-1:0]   free_next;
   logic [WORD_BITS-1:0]   top;
   logic [WORD_BITS-1:0]   word_next;
   logic                   word_full;
   logic                   item_done;
   logic                   flush;
   logic                   emit;

   always_comb begin
      state_in     = state_ff;
      partial_in   = partial_ff;
      free_in      = free_ff;
      bits_in      = bits_ff;
      len_in       = len_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;

      out_ok    = !out_valid_ff || rsp_pop;
      take      = (len_ff < LEN_BITS'(free_ff)) ? len_ff : LEN_BITS'(free_ff);
      free_next = free_ff - FREE_BITS'(take);
      len_next  = len_ff - take;
      top       = bits_ff[VALUE_BITS-1 -: WORD_BITS];
      word_next = partial_ff | (top >> (FREE_BITS'(WORD_BITS) - free_ff));
      word_full = (free_next == '0);
      item_done = (len_next == '0);
      flush     = last_ff && item_done && !word_full
                  && (free_next != FREE_BITS'(WORD_BITS));
      emit      = word_full || flush;

      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               bits_in  = q_data.bits;
               len_in   = q_data.len;
               last_in  = q_data.last;
               state_in = BK_PACK;
            end
         end
         BK_PACK: begin
            if (out_ok || !emit) begin
               bits_in    = bits_ff << take;
               len_in     = len_next;
               partial_in = word_next;
               free_in    = free_next;
               if (emit) begin
                  out_valid_in          = 1'b1;
                  out_data_in.word      = word_next;
                  out_data_in.last_word = last_ff && item_done;
                  partial_in            = '0;
                  free_in               = FREE_BITS'(WORD_BITS);
               end
               if (item_done) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         partial_ff   <= '0;
         free_ff      <= FREE_BITS'(WORD_BITS);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         partial_ff   <= partial_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff     <= bits_in;
      len_ff      <= len_in;
      last_ff     <= last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_data_ff;

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff != '0 && free_ff <= FREE_BITS'(WORD_BITS))
      else $error("free bit count out of range");

   a_pop_in_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE && !q_status.empty))
      else $error("task taken outside idle");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_PACK && item_done && last_ff && (out_ok || !emit))
      |=> (free_ff == FREE_BITS'(WORD_BITS) && partial_ff == '0))
      else $error("word not empty after final item");

   a_word_from_pack: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == BK_PACK))
      else $error("word emitted outside packing");

endmodule

// ----- design/variable_width_bit_packer_core.sv -----
// Variable-width bit packer, MSB first, 8-bit output words.
// A request's first word passes the task queue, the back end's load step and its packing step
// into the output register on the rsp ports. The back end loads a request only when idle, then
// packs one chunk per cycle (the bits that land in one word), stalling on a full output register.
// Reset: synchronous; empties the task queue and output register, starts an empty word.
// Depends on vwbp_pkg, vwbp_front, vwbp_queue and vwbp_back.
module variable_width_bit_packer_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  vwbp_pkg::req_type req_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output vwbp_pkg::rsp_type rsp_item
);
   import vwbp_pkg::*;

   queue_status_type q_status;
   task_type         q_wdata;
   task_type         q_rdata;
   logic             q_push;
   logic             q_pop;

   vwbp_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   vwbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_wdata  (q_wdata),
      .q_pop    (q_pop),
      .q_rdata  (q_rdata),
      .q_status (q_status)
   );

   vwbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_rdata),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for variable_width_bit_packer_core: drives requests, predicts the packed words
// and checks each word on pop. Depends on vwbp_pkg and the packer RTL.
module testbench;
   import vwbp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_item  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_item;

   rsp_type              expected_words[$];
   logic [WORD_BITS-1:0] pend_word      = '0;
   int                   pend_free      = WORD_BITS;
   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;
   int                   hold_cycles    = 0;
   int                   error_count    = 0;
   int                   cycle_count    = 0;

   variable_width_bit_packer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void note_mismatch(string what, rsp_type exp_w, rsp_type got_w);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH %s at cycle %0d: expected word %02h last %0b, got word %02h last %0b",
                  what, cycle_count, exp_w.word, exp_w.last_word, got_w.word, got_w.last_word);
   endfunction

   function automatic void emit_word(logic last_flag);
      rsp_type w;
      w.word      = pend_word;
      w.last_word = last_flag;
      expected_words.push_back(w);
      pend_word = '0;
      pend_free = WORD_BITS;
   endfunction

   function automatic void pack_bits(req_type r);
      int          n;
      int          k;
      logic [63:0] v;
      logic [63:0] chunk;
      logic [63:0] placed;
      n = int'(r.bit_count);
      if (n > VALUE_BITS)
         n = VALUE_BITS;
      v = 64'(r.value) & ((64'd1 << n) - 64'd1);
      while (n > 0) begin
         k      = (n < pend_free) ? n : pend_free;
         chunk  = (v >> (n - k)) & ((64'd1 << k) - 64'd1);
         placed = chunk << (pend_free - k);
         pend_word = pend_word | placed[WORD_BITS-1:0];
         pend_free -= k;
         n         -= k;
         if (pend_free == 0)
            emit_word(r.last && n == 0);
      end
      if (r.last && pend_free < WORD_BITS)
         emit_word(1'b1);
   endfunction

   function automatic req_type make_request(logic [31:0] value, int count, logic last);
      req_type r;
      r.value     = value;
      r.bit_count = CNT_BITS'(count);
      r.last      = last;
      return r;
   endfunction

   function automatic req_type random_request(logic last);
      int sel;
      int count;
      sel = $urandom_range(99);
      if (sel < 10)
         count = 0;
      else if (sel < 25)
         count = VALUE_BITS;
      else if (sel < 33)
         count = $urandom_range(63, VALUE_BITS + 1);
      else
         count = $urandom_range(VALUE_BITS - 1, 1);
      return make_request($urandom, count, last);
   endfunction

   // hold push high until the request is taken
   task automatic send_request(input req_type r);
      bit accepted;
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_item <= r;
      do begin
         @(posedge clock);
         accepted = !req_full;
      end while (!accepted);
      pack_bits(r);
   endtask

   task automatic idle_line();
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_words
      rsp_type exp_w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            exp_w = '0;
            note_mismatch("unexpected word", exp_w, rsp_item);
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_item.word !== exp_w.word || rsp_item.last_word !== exp_w.last_word)
               note_mismatch("field", exp_w, rsp_item);
         end
      end
   end

   task automatic test_special_cases();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_request(make_request(32'hFFFF_FFFF, 32, 1'b0));
      send_request(make_request(32'hA5A5_A5A5, 3, 1'b0));
      send_request(make_request(32'hFFFF_FFFF, 0, 1'b1));
      send_request(make_request(32'h0000_0000, 0, 1'b1));
      send_request(make_request(32'h1234_5678, 8, 1'b1));
      send_request(make_request(32'hDEAD_BEEF, 63, 1'b0));
      send_request(make_request(32'hFFFF_FFFF, 33, 1'b1));
      send_request(make_request(32'h8000_0001, 1, 1'b0));
      send_request(make_request(32'hFFFF_FFFE, 7, 1'b0));
      send_request(make_request(32'hFFFF_FFFF, 9, 1'b1));
      send_request(make_request(32'h0000_0000, 32, 1'b1));
      send_request(make_request(32'hFFFF_FFFF, 31, 1'b0));
      send_request(make_request(32'h0000_0001, 1, 1'b1));
      send_request(make_request(32'h5555_AAAA, 40, 1'b1));
      send_request(make_request(32'hCAFE_F00D, 0, 1'b0));
      send_request(make_request(32'h0F0F_0F0F, 5, 1'b0));
      send_request(make_request(32'h0000_0000, 0, 1'b0));
      send_request(make_request(32'h7FFF_FFFF, 32, 1'b1));
      idle_line();
      wait_drained();
   endtask

   task automatic test_full_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 150;
      for (int i = 0; i < 10; i++)
         send_request(make_request($urandom, VALUE_BITS, i == 9));
      idle_line();
      wait_drained();
   endtask

   task automatic test_drain_pause();
      send_idle_pct  = 0;
      recv_stall_pct = 30;
      for (int i = 0; i < 4; i++)
         send_request(random_request(1'b0));
      idle_line();
      wait_drained();
      for (int i = 0; i < 4; i++)
         send_request(random_request(i == 3));
      idle_line();
      wait_drained();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int item_total);
      int sent;
      int len;
      req_type r;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_total) begin
         len = $urandom_range(8, 1);
         for (int i = 0; i < len; i++) begin
            r = random_request(i == len - 1);
            if ($urandom_range(99) < 8)
               r.last = 1'($urandom_range(1));
            send_request(r);
            sent++;
         end
      end
      idle_line();
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_full_stall();
      test_drain_pause();
      test_random_traffic(0, 0, 92);
      test_random_traffic(80, 0, 92);
      test_random_traffic(0, 80, 92);
      test_random_traffic(26, 26, 92);
      if (expected_words.size() != 0)
         error_count++;
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
